/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of the header decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* rtl/gclhd_pkg.sv */
// Package with the item types, result kinds and constants of the header decoder.
`timescale 1ns / 1ps
package gclhd_pkg;

	localparam int HDR_BITS      = 64;
	localparam int NULL_BITS     = 60;
	localparam int SCAN_BITS     = 61;
	localparam int OFFSET_BITS   = 9;
	localparam int COUNT_BITS    = 6;
	localparam int CNT_BITS      = 6;

	localparam logic [1:0] TAG_FORWARD = 2'b01;
	localparam logic [1:0] TAG_LAYOUT  = 2'b11;

	localparam logic [2:0] KIND_UNSUPPORTED = 3'd0;
	localparam logic [2:0] KIND_FORWARD     = 3'd1;
	localparam logic [2:0] KIND_SIZE_ONLY   = 3'd2;
	localparam logic [2:0] KIND_SLOT        = 3'd3;
	localparam logic [2:0] KIND_SUMMARY     = 3'd4;

	localparam logic [OFFSET_BITS-1:0] SLOT_BYTES = 9'd8;
	localparam logic [OFFSET_BITS-1:0] DATA_BYTES = 9'd4;

	typedef struct packed {
		logic [HDR_BITS-1:0]  header_word;
		logic [NULL_BITS-1:0] slot_null_mask;
	} hdr_in_t;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [8:0]  slot_offset;
		logic [60:0] object_bytes;
		logic [5:0]  pointer_total;
		logic [63:0] forward_target;
		logic        last_of_run;
	} hdr_out_t;

	typedef struct packed {
		logic                   started;
		logic [OFFSET_BITS-1:0] offset;
		logic [COUNT_BITS-1:0]  live;
	} scan_state_t;

	typedef struct packed {
		logic        emit;
		logic        slot;
		scan_state_t next;
	} scan_step_t;

endpackage

/* rtl/gclhd_scan_unit.sv */
// Shared step unit that consumes one layout bit per cycle.
`timescale 1ns / 1ps
module gclhd_scan_unit
	import gclhd_pkg::*;
(
	input  logic        layout_bit,
	input  logic        null_bit,
	input  scan_state_t cur,
	output scan_step_t  step
);

	always_comb begin
		step      = '0;
		step.next = cur;
		if (!cur.started) begin
			step.next.started = layout_bit;
		end else if (layout_bit) begin
			step.slot        = 1'b1;
			step.emit        = !null_bit;
			step.next.offset = cur.offset + SLOT_BYTES;
			step.next.live   = cur.live + COUNT_BITS'(!null_bit);
		end else begin
			step.next.offset = cur.offset + DATA_BYTES;
		end
	end

endmodule

/* rtl/gc_layout_header_decoder.sv */
// Top level of the heap object header decoder.
`timescale 1ns / 1ps
// Forwarding, size-only and unsupported headers give their single result in the
// cycle after the item is accepted, and busy stays low, so such an item may be
// started every cycle. A layout bitvector header is walked one bit per cycle by
// a shared step unit over its 61 layout bits in ST_SCAN, followed by ST_SUMMARY:
// busy is high in both states, and the summary result appears in the first cycle
// that busy is low again. Each non-null pointer slot yields one result in the
// cycle after its bit is scanned. Results are shown for exactly one cycle under
// result_strobe and cannot be held off by the receiver.
module gc_layout_header_decoder
	import gclhd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  hdr_in_t  request,
	output logic     result_strobe,
	output hdr_out_t result
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SUMMARY
	} state_t;

	state_t                  state_q;
	logic [SCAN_BITS-1:0]    bits_q;
	logic [NULL_BITS-1:0]    null_q;
	logic [CNT_BITS-1:0]     cnt_q;
	scan_state_t             scan_q;
	logic                    strobe_q;
	hdr_out_t                result_q;
	scan_step_t              step;
	logic                    accept;
	logic [1:0]              tag;

	assign accept        = start && (state_q == ST_IDLE);
	assign tag           = request.header_word[1:0];
	assign busy          = (state_q != ST_IDLE);
	assign result_strobe = strobe_q;
	assign result        = result_q;

	gclhd_scan_unit u_scan (
		.layout_bit (bits_q[SCAN_BITS-1]),
		.null_bit   (null_q[0]),
		.cur        (scan_q),
		.step       (step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
			cnt_q    <= '0;
			scan_q   <= '0;
			bits_q   <= '0;
			null_q   <= '0;
			result_q <= '0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						result_q             <= '0;
						result_q.last_of_run <= 1'b1;
						if (tag == TAG_FORWARD) begin
							strobe_q                <= 1'b1;
							result_q.result_kind    <= KIND_FORWARD;
							result_q.forward_target <= {request.header_word[63:2], 2'b00};
						end else if (tag != TAG_LAYOUT) begin
							strobe_q             <= 1'b1;
							result_q.result_kind <= KIND_UNSUPPORTED;
						end else if (!request.header_word[2]) begin
							strobe_q              <= 1'b1;
							result_q.result_kind  <= KIND_SIZE_ONLY;
							result_q.object_bytes <= request.header_word[63:3];
						end else begin
							bits_q  <= request.header_word[63:3];
							null_q  <= request.slot_null_mask;
							cnt_q   <= CNT_BITS'(SCAN_BITS);
							scan_q  <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					strobe_q             <= step.emit;
					result_q             <= '0;
					result_q.result_kind <= KIND_SLOT;
					result_q.slot_offset <= scan_q.offset;
					scan_q               <= step.next;
					bits_q               <= {bits_q[SCAN_BITS-2:0], 1'b0};
					if (step.slot) begin
						null_q <= {1'b0, null_q[NULL_BITS-1:1]};
					end
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_BITS'(1)) begin
						state_q <= ST_SUMMARY;
					end
				end
				ST_SUMMARY: begin
					strobe_q               <= 1'b1;
					result_q               <= '0;
					result_q.result_kind   <= KIND_SUMMARY;
					result_q.object_bytes  <= 61'(scan_q.offset);
					result_q.pointer_total <= scan_q.live;
					result_q.last_of_run   <= 1'b1;
					state_q                <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/gclhd_checker.sv */
// Port-level checker for the header decoder and its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gclhd_checker
	import gclhd_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input hdr_in_t  request,
	input logic     result_strobe,
	input hdr_out_t result
);

	logic fwd_accept;
	logic fwd_result;
	logic open_run;
	logic slot_kind;
	logic slot_shape;
	logic busy_start;
	logic run_result;

	assign fwd_accept = start && !busy && (request.header_word[1:0] == TAG_FORWARD);
	assign fwd_result = result_strobe && (result.result_kind == KIND_FORWARD)
		&& result.last_of_run;
	assign open_run   = result_strobe && !result.last_of_run;
	assign slot_kind  = result_strobe && (result.result_kind == KIND_SLOT);
	assign slot_shape = !result.last_of_run && (result.slot_offset[1:0] == 2'b00);
	assign busy_start = busy && start;
	assign run_result = !result_strobe || (result.result_kind == KIND_SLOT)
		|| (result.result_kind == KIND_SUMMARY);

	`ASSERT_NEXT(a_forward_result, clk, arst_n, fwd_accept, fwd_result)
	`ASSERT_SAME(a_open_run_busy, clk, arst_n, open_run, busy)
	`ASSERT_SAME(a_slot_not_last, clk, arst_n, slot_kind, slot_shape)
	`ASSERT_NEXT(a_busy_no_accept_result, clk, arst_n, busy_start, run_result)

endmodule

bind gc_layout_header_decoder gclhd_checker u_gclhd_checker (.*);

/* verif/tb_top.sv */
// Self-checking testbench for the heap object header decoder.
`timescale 1ns / 1ps
module tb_top;
	import gclhd_pkg::*;

	localparam logic [1:0] TAG_EMPTY = 2'b00;
	localparam logic [1:0] TAG_SPARE = 2'b10;
	localparam int RANDOM_ITEMS = 300;
	localparam int QUIET_TAIL   = 60;
	localparam int DRAIN_LIMIT  = 2000;
	localparam int SETTLE       = 80;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	hdr_in_t  request;
	logic     result_strobe;
	hdr_out_t result;

	hdr_out_t expected_results[$];
	int       fail_count;
	bit       idle_enabled;

	gc_layout_header_decoder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.result_strobe(result_strobe),
		.result       (result)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic void decode_header(hdr_in_t it);
		hdr_out_t    r;
		logic [63:0] h;
		logic        started;
		int          offset;
		int          live;
		int          slot;
		int          b;
		h = it.header_word;
		r = '0;
		r.last_of_run = 1'b1;
		if (h[1:0] == TAG_FORWARD) begin
			r.result_kind = KIND_FORWARD;
			r.forward_target = {h[63:2], 2'b00};
			expected_results.push_back(r);
			return;
		end
		if (h[1:0] != TAG_LAYOUT) begin
			r.result_kind = KIND_UNSUPPORTED;
			expected_results.push_back(r);
			return;
		end
		if (!h[2]) begin
			r.result_kind = KIND_SIZE_ONLY;
			r.object_bytes = h[63:3];
			expected_results.push_back(r);
			return;
		end
		started = 1'b0;
		offset = 0;
		live = 0;
		slot = 0;
		for (b = 63; b >= 3; b--) begin
			if (!started) begin
				started = h[b];
			end else if (h[b]) begin
				if (!it.slot_null_mask[slot]) begin
					r = '0;
					r.result_kind = KIND_SLOT;
					r.slot_offset = offset[8:0];
					expected_results.push_back(r);
					live++;
				end
				slot++;
				offset += 8;
			end else begin
				offset += 4;
			end
		end
		r = '0;
		r.result_kind = KIND_SUMMARY;
		r.object_bytes = 61'(offset);
		r.pointer_total = live[5:0];
		r.last_of_run = 1'b1;
		expected_results.push_back(r);
	endfunction

	always @(posedge clk) begin
		hdr_out_t want;
		if (arst_n && result_strobe) begin
			if (expected_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("unexpected result kind=%0d offset=%0d bytes=%h total=%0d fwd=%h last=%b",
						result.result_kind, result.slot_offset, result.object_bytes,
						result.pointer_total, result.forward_target, result.last_of_run);
				end
			end else begin
				want = expected_results.pop_front();
				if (result.result_kind !== want.result_kind
						|| result.slot_offset !== want.slot_offset
						|| result.object_bytes !== want.object_bytes
						|| result.pointer_total !== want.pointer_total
						|| result.forward_target !== want.forward_target
						|| result.last_of_run !== want.last_of_run) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("mismatch expected kind=%0d offset=%0d bytes=%h total=%0d fwd=%h last=%b",
							want.result_kind, want.slot_offset, want.object_bytes,
							want.pointer_total, want.forward_target, want.last_of_run);
						$display("         actual   kind=%0d offset=%0d bytes=%h total=%0d fwd=%h last=%b",
							result.result_kind, result.slot_offset, result.object_bytes,
							result.pointer_total, result.forward_target, result.last_of_run);
					end
				end
			end
		end
	end

	task automatic pause(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic send_item(input logic [63:0] hdr, input logic [59:0] nulls);
		hdr_in_t it;
		it.header_word = hdr;
		it.slot_null_mask = nulls;
		start <= 1'b1;
		request <= it;
		do @(posedge clk); while (busy);
		decode_header(it);
		@(negedge clk);
		if (idle_enabled && $urandom_range(0, 3) == 0) begin
			pause($urandom_range(1, 13));
		end
	endtask

	task automatic test_unsupported_tags();
		send_item({62'h0, TAG_EMPTY}, '0);
		send_item({62'h3FFF_FFFF_FFFF_FFFF, TAG_SPARE}, '1);
		send_item({62'(rand64() >> 2), TAG_EMPTY}, 60'(rand64()));
		send_item({62'(rand64() >> 2), TAG_SPARE}, 60'(rand64()));
	endtask

	task automatic test_forwarding();
		send_item({62'h0, TAG_FORWARD}, '0);
		send_item({62'h3FFF_FFFF_FFFF_FFFF, TAG_FORWARD}, '1);
		send_item({62'(rand64() >> 2), TAG_FORWARD}, 60'(rand64()));
	endtask

	task automatic test_size_only();
		send_item({61'h0, 1'b0, TAG_LAYOUT}, '0);
		send_item({61'h1FFF_FFFF_FFFF_FFFF, 1'b0, TAG_LAYOUT}, '1);
		send_item({61'(rand64() >> 3), 1'b0, TAG_LAYOUT}, 60'(rand64()));
	endtask

	task automatic test_layout_edges();
		send_item({61'h0, 1'b1, TAG_LAYOUT}, '0);
		send_item({61'h0, 1'b1, TAG_LAYOUT}, '1);
		send_item(64'h0000_0000_0000_000F, '0);
		send_item(64'h0000_0000_0000_001F, '0);
		send_item(64'h0000_0000_0000_001F, 60'hFFF_FFFF_FFFF_FFFE);
		send_item(64'h8000_0000_0000_0007, '1);
		send_item(64'hFFFF_FFFF_FFFF_FFFF, '0);
		send_item(64'hFFFF_FFFF_FFFF_FFFF, '1);
		send_item(64'hFFFF_FFFF_FFFF_FFFF, 60'h555_5555_5555_5555);
		send_item(64'hFFFF_FFFF_FFFF_FFFF, 60'hAAA_AAAA_AAAA_AAAA);
		send_item(64'hAAAA_AAAA_AAAA_AAAF, 60'h800_0000_0000_0000);
		send_item(64'h0000_0000_0000_00FF, 60'hFFF_FFFF_FFFF_FFF0);
	endtask

	function automatic logic [63:0] rand_layout();
		logic [63:0] w;
		logic [63:0] below;
		int          lead;
		w = rand64();
		case ($urandom_range(0, 2))
			0: w = w & rand64();
			1: w = w | rand64();
			default: ;
		endcase
		lead = $urandom_range(3, 63);
		if ($urandom_range(0, 5) == 0) begin
			lead = $urandom_range(3, 10);
		end
		below = (64'd1 << lead) - 64'd1;
		w = (w & below) | (64'd1 << lead);
		if ($urandom_range(0, 30) == 0) begin
			w = '0;
		end
		return {w[63:3], 1'b1, TAG_LAYOUT};
	endfunction

	function automatic logic [59:0] rand_nulls();
		logic [63:0] m;
		case ($urandom_range(0, 5))
			0: m = '0;
			1: m = '1;
			2: m = rand64() & rand64();
			3: m = rand64() | rand64();
			default: m = rand64();
		endcase
		return m[59:0];
	endfunction

	task automatic test_random_mix(input int count);
		int i;
		int pick;
		for (i = 0; i < count; i++) begin
			idle_enabled = (i < count - QUIET_TAIL) && ((i / 40) % 3 != 2);
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				send_item(rand_layout(), rand_nulls());
			end else if (pick < 55) begin
				send_item({61'(rand64() >> 3), 1'b1, TAG_LAYOUT}, rand_nulls());
			end else if (pick < 70) begin
				send_item({62'(rand64() >> 2), TAG_FORWARD}, 60'(rand64()));
			end else if (pick < 85) begin
				send_item({61'(rand64() >> 3), 1'b0, TAG_LAYOUT}, 60'(rand64()));
			end else begin
				send_item({62'(rand64() >> 2), $urandom_range(0, 1) ? TAG_SPARE : TAG_EMPTY},
					60'(rand64()));
			end
		end
	endtask

	task automatic finish_run();
		int waited;
		start <= 1'b0;
		waited = 0;
		while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE) @(posedge clk);
		if (expected_results.size() != 0) begin
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	endtask

	initial begin
		fail_count = 0;
		idle_enabled = 1'b1;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_unsupported_tags();
		test_forwarding();
		test_size_only();
		test_layout_edges();
		test_random_mix(RANDOM_ITEMS);
		finish_run();
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/gclhd_pkg.sv
rtl/gclhd_scan_unit.sv
rtl/gc_layout_header_decoder.sv
rtl/gclhd_checker.sv
verif/tb_top.sv
